[design/set_assoc_lru_cache_tags_defines.svh]
// assertion macros used by the checker file
`ifndef SET_ASSOC_LRU_CACHE_TAGS_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_TAGS_DEFINES_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define SALCT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on the rising clock, off during reset
`define SALCT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/salct_pkg.sv]
package salct_pkg;

  // access command codes
  typedef enum logic [1:0] {
    ACC_READ  = 2'd0,
    ACC_WRITE = 2'd1,
    ACC_INVAL = 2'd2,
    ACC_NOP   = 2'd3
  } access_e;

  // fixed word field widths
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned WAY_OUT_W = 3;
  localparam int unsigned VBLK_W    = 27;

  // controller to datapath
  typedef struct packed {
    logic clr_step;  // write one reset row of the clearing pass
    logic capture;   // take the input word and read its set
    logic update;    // write back the set and load the output register
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;  // clearing pass is at its last row
  } ctl_stat_t;

endpackage

[design/set_assoc_lru_cache_tags.sv]
// Tag and LRU policy store of a set-associative cache. Each word in carries a
// command (read, write, invalidate, nop) and a byte address; each produces exactly one
// word out with hit, way and the evicted line, if any. Reads and writes allocate on a
// miss into the lowest invalid way, else the least recently used way. After reset the
// block runs a clearing pass (one set row per cycle) with in_ready_o low. An access then
// reads the set row from the set memory into a register, then compares all ways,
// updates the row and writes it back through the single write port. A new word is
// taken while the previous result still waits in the output register. LINE_BYTES and
// SETS must be powers of two.
module set_assoc_lru_cache_tags #(
  parameter int unsigned SETS       = 128,
  parameter int unsigned WAYS       = 8,
  parameter int unsigned LINE_BYTES = 32,
  parameter int unsigned ADDR_BITS  = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request word
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [salct_pkg::CMD_W-1:0]     command_i,
  input  logic [salct_pkg::ADDR_W-1:0]    address_i,
  // result word
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            hit_o,
  output logic [salct_pkg::WAY_OUT_W-1:0] way_o,
  output logic                            victim_valid_o,
  output logic                            victim_dirty_o,
  output logic [salct_pkg::VBLK_W-1:0]    victim_block_o
);

  // command and status between controller and datapath
  salct_pkg::ctl_cmd_t  cmd;
  salct_pkg::ctl_stat_t stat;

  // sequencing: clearing pass, accept, lookup and write back
  salct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  // set memory, way compare, replacement choice and result register
  salct_dpath #(
    .SETS       (SETS),
    .WAYS       (WAYS),
    .LINE_BYTES (LINE_BYTES),
    .ADDR_BITS  (ADDR_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .command_i      (command_i),
    .address_i      (address_i),
    .hit_o          (hit_o),
    .way_o          (way_o),
    .victim_valid_o (victim_valid_o),
    .victim_dirty_o (victim_dirty_o),
    .victim_block_o (victim_block_o)
  );

endmodule

[design/salct_ctrl.sv]
module salct_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 out_ready_i,
  input  salct_pkg::ctl_stat_t stat_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  output salct_pkg::ctl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_CLEAR:  cmd_o.clr_step = 1'b1;
      ST_IDLE:   cmd_o.capture  = in_valid_i;
      ST_LOOKUP: cmd_o.update   = !out_valid_q || out_ready_i;
      default:   cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      in_ready_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          if (stat_i.clr_last) begin
            state_q    <= ST_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_valid_i && in_ready_q) begin
            state_q    <= ST_LOOKUP;
            in_ready_q <= 1'b0;
          end
        end
        ST_LOOKUP: begin
          if (!out_valid_q || out_ready_i) begin
            state_q     <= ST_IDLE;
            in_ready_q  <= 1'b1;
            out_valid_q <= 1'b1;
          end
        end
        default: begin
          state_q    <= ST_CLEAR;
          in_ready_q <= 1'b0;
        end
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule

[design/salct_dpath.sv]
module salct_dpath #(
  parameter int unsigned SETS       = 128,
  parameter int unsigned WAYS       = 8,
  parameter int unsigned LINE_BYTES = 32,
  parameter int unsigned ADDR_BITS  = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  salct_pkg::ctl_cmd_t                   cmd_i,
  output salct_pkg::ctl_stat_t                  stat_o,
  input  logic [salct_pkg::CMD_W-1:0]           command_i,
  input  logic [salct_pkg::ADDR_W-1:0]          address_i,
  output logic                                  hit_o,
  output logic [salct_pkg::WAY_OUT_W-1:0]       way_o,
  output logic                                  victim_valid_o,
  output logic                                  victim_dirty_o,
  output logic [salct_pkg::VBLK_W-1:0]          victim_block_o
);

  localparam int unsigned AW_EFF = (ADDR_BITS < salct_pkg::ADDR_W) ? ADDR_BITS
                                                                   : salct_pkg::ADDR_W;
  localparam int unsigned OFF_W  = $clog2(LINE_BYTES);
  localparam int unsigned BLK_W  = AW_EFF - OFF_W;
  localparam int unsigned SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned ENT_W  = 2 + BLK_W + RANK_W;
  localparam int unsigned V_BIT  = ENT_W - 1;
  localparam int unsigned D_BIT  = ENT_W - 2;

  // set memory, one row of WAYS entries {valid, dirty, block, rank} per set
  logic [WAYS-1:0][ENT_W-1:0] mem_q [SETS];
  logic [WAYS-1:0][ENT_W-1:0] rdata_q;
  logic [WAYS-1:0][ENT_W-1:0] new_row;
  logic [WAYS-1:0][ENT_W-1:0] rst_row;

  logic [SET_W-1:0]           clr_idx_q;
  logic [BLK_W-1:0]           in_block;
  logic [BLK_W+SET_W-1:0]     in_block_ext;
  logic [SET_W-1:0]           in_set;
  logic [salct_pkg::CMD_W-1:0] cmd_q;
  logic [BLK_W-1:0]           block_q;
  logic [SET_W-1:0]           set_q;

  logic [WAYS-1:0]   v_vec, d_vec, hit_vec;
  logic [BLK_W-1:0]  tag_arr  [WAYS];
  logic [RANK_W-1:0] rank_arr [WAYS];
  logic              found, empty, is_rw, is_wr, is_inv, victim;
  logic [RANK_W-1:0] hit_way, inv_way, lru_way, sel_way, sel_rank;

  logic                              hit_q, vv_q, vd_q;
  logic [salct_pkg::WAY_OUT_W-1:0]   way_q;
  logic [salct_pkg::VBLK_W-1:0]      vb_q;

  assign in_block     = address_i[AW_EFF-1:OFF_W];
  assign in_block_ext = (BLK_W+SET_W)'(in_block);
  assign in_set       = (SETS == 1) ? '0 : in_block_ext[SET_W-1:0];

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      rst_row[i] = {1'b0, 1'b0, {BLK_W{1'b0}}, RANK_W'(i)};
    end
  end

  // clearing pass row counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_idx_q <= clr_idx_q + 1'b1;
    end
  end

  assign stat_o.clr_last = (clr_idx_q == SET_W'(SETS - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      mem_q[clr_idx_q] <= rst_row;
    end else if (cmd_i.update) begin
      mem_q[set_q] <= new_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rdata_q <= mem_q[in_set];
      cmd_q   <= command_i;
      block_q <= in_block;
      set_q   <= in_set;
    end
  end

  // lookup over the ways of the set
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      v_vec[i]    = rdata_q[i][V_BIT];
      d_vec[i]    = rdata_q[i][D_BIT];
      tag_arr[i]  = rdata_q[i][BLK_W+RANK_W-1:RANK_W];
      rank_arr[i] = rdata_q[i][RANK_W-1:0];
      hit_vec[i]  = v_vec[i] && (tag_arr[i] == block_q);
    end
    found   = |hit_vec;
    empty   = ~&v_vec;
    hit_way = '0;
    inv_way = '0;
    lru_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (hit_vec[i]) hit_way = RANK_W'(i);
      if (!v_vec[i]) inv_way = RANK_W'(i);
      if (rank_arr[i] == RANK_W'(WAYS - 1)) lru_way = RANK_W'(i);
    end
    is_wr  = (cmd_q == salct_pkg::ACC_WRITE);
    is_rw  = (cmd_q == salct_pkg::ACC_READ) || is_wr;
    is_inv = (cmd_q == salct_pkg::ACC_INVAL);
    if ((is_rw || is_inv) && found) begin
      sel_way = hit_way;
    end else if (is_rw) begin
      sel_way = empty ? inv_way : lru_way;
    end else begin
      sel_way = '0;
    end
    victim   = is_rw && !found && !empty;
    sel_rank = rank_arr[sel_way];

    new_row = rdata_q;
    if (is_rw) begin
      if (!found) begin
        new_row[sel_way][V_BIT] = 1'b1;
        new_row[sel_way][BLK_W+RANK_W-1:RANK_W] = block_q;
      end
      if (is_wr) begin
        new_row[sel_way][D_BIT] = 1'b1;
      end else if (!found) begin
        new_row[sel_way][D_BIT] = 1'b0;
      end
      // recency: ways more recent than the touched one age by one
      for (int i = 0; i < WAYS; i++) begin
        if (rank_arr[i] < sel_rank) begin
          new_row[i][RANK_W-1:0] = rank_arr[i] + 1'b1;
        end
      end
      new_row[sel_way][RANK_W-1:0] = '0;
    end else if (is_inv && found) begin
      new_row[sel_way][V_BIT] = 1'b0;
      new_row[sel_way][D_BIT] = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      hit_q <= (is_rw || is_inv) && found;
      way_q <= salct_pkg::WAY_OUT_W'(sel_way);
      vv_q  <= victim;
      vd_q  <= victim && d_vec[sel_way];
      vb_q  <= victim ? salct_pkg::VBLK_W'(tag_arr[sel_way]) : '0;
    end
  end

  assign hit_o          = hit_q;
  assign way_o          = way_q;
  assign victim_valid_o = vv_q;
  assign victim_dirty_o = vd_q;
  assign victim_block_o = vb_q;

endmodule

[design/salct_checker.sv]
`include "set_assoc_lru_cache_tags_defines.svh"

module salct_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic [salct_pkg::CMD_W-1:0]     command_i,
  input logic [salct_pkg::ADDR_W-1:0]    address_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic                            hit_o,
  input logic [salct_pkg::WAY_OUT_W-1:0] way_o,
  input logic                            victim_valid_o,
  input logic                            victim_dirty_o,
  input logic [salct_pkg::VBLK_W-1:0]    victim_block_o
);

  logic in_acc;
  logic res_fields;

  assign in_acc     = in_valid_i && in_ready_o;
  assign res_fields = |{hit_o, way_o, victim_valid_o, victim_dirty_o, victim_block_o,
                        command_i, address_i};

  // one word at a time: ready drops right after an accept
  `SALCT_ASSERT_NXT(a_one_in_flight, in_acc, !in_ready_o, "ready high after accept")

  // a new result shows only after its word was taken: accept, then lookup
  `SALCT_ASSERT_IMP(a_result_source, $rose(out_valid_o), $past(in_acc, 2),
    "result without a word in")

  // a victim is only reported on a miss
  `SALCT_ASSERT_IMP(a_victim_miss, out_valid_o && victim_valid_o && res_fields, !hit_o,
    "victim reported on a hit")

  // a stalled result holds
  `SALCT_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(hit_o) && $stable(way_o) && $stable(victim_block_o),
    "stalled result changed")

endmodule

bind set_assoc_lru_cache_tags salct_checker u_checker (.*);

[tb/tb_set_assoc_lru_cache_tags.sv]
module tb_set_assoc_lru_cache_tags;
  timeunit 1ns;
  timeprecision 1ps;

  import salct_pkg::*;

  // geometry of the instance under test
  localparam int NUM_SETS   = 128;
  localparam int NUM_WAYS   = 8;
  localparam int OFS_BITS   = 5;   // log2 of the line size
  localparam int SET_BITS   = 7;   // log2 of the set count
  localparam int CYCLE_CAP  = 200000;
  localparam int RAND_WORDS = 750;
  localparam int TAIL_WORDS = 80;  // last stretch of the run runs without idling
  localparam int HOLD_AFTER = 40;  // words in before the long receiver hold-off
  localparam int HOLD_LEN   = 300;

  // one request word
  typedef struct packed {
    access_e     cmd;
    logic [31:0] addr;
  } access_t;

  // one result word
  typedef struct packed {
    logic                 hit;
    logic [WAY_OUT_W-1:0] way;
    logic                 vic_valid;
    logic                 vic_dirty;
    logic [VBLK_W-1:0]    vic_block;
  } lookup_t;

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic [CMD_W-1:0]     command_i   = ACC_NOP;
  logic [ADDR_W-1:0]    address_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 hit_o;
  logic [WAY_OUT_W-1:0] way_o;
  logic                 victim_valid_o;
  logic                 victim_dirty_o;
  logic [VBLK_W-1:0]    victim_block_o;

  set_assoc_lru_cache_tags #(
    .SETS      (NUM_SETS),
    .WAYS      (NUM_WAYS),
    .LINE_BYTES(1 << OFS_BITS),
    .ADDR_BITS (32)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .address_i     (address_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .hit_o         (hit_o),
    .way_o         (way_o),
    .victim_valid_o(victim_valid_o),
    .victim_dirty_o(victim_dirty_o),
    .victim_block_o(victim_block_o)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // shadow copy of the tag store, one entry per set and way
  logic              line_ok  [NUM_SETS][NUM_WAYS];
  logic              line_dty [NUM_SETS][NUM_WAYS];
  logic [VBLK_W-1:0] line_blk [NUM_SETS][NUM_WAYS];
  logic [2:0]        line_age [NUM_SETS][NUM_WAYS];  // 0 is most recent

  access_t access_q[$];      // words still to be offered
  lookup_t lookup_due_q[$];  // predicted results in arrival order

  int  fail_cnt  = 0;
  int  words_in  = 0;
  bit  quiet_run = 1'b0;     // set for the final stretch: no idling on either side
  bit  rx_hold   = 1'b0;

  // applies one access to the shadow store and returns the result it must produce
  function automatic lookup_t tag_access(access_e cmd, logic [31:0] addr);
    lookup_t           r;
    logic [VBLK_W-1:0] blk;
    int                s;
    int                w;
    int                worst;
    bit                found;
    bit                empty;
    logic [2:0]        old_age;
    r     = '0;
    blk   = addr[31:OFS_BITS];
    s     = blk[SET_BITS-1:0];
    w     = 0;
    found = 1'b0;
    empty = 1'b0;
    // the hit check comes before any invalid-way scan
    if (cmd != ACC_NOP) begin
      for (int i = 0; i < NUM_WAYS; i++) begin
        if (!found && line_ok[s][i] && line_blk[s][i] == blk) begin
          found = 1'b1;
          w     = i;
        end
      end
    end
    case (cmd)
      ACC_READ, ACC_WRITE: begin
        if (found) begin
          r.hit = 1'b1;
          if (cmd == ACC_WRITE) line_dty[s][w] = 1'b1;
        end else begin
          // allocate: lowest invalid way first
          for (int i = 0; i < NUM_WAYS; i++) begin
            if (!empty && !line_ok[s][i]) begin
              empty = 1'b1;
              w     = i;
            end
          end
          // set full: oldest rank, lowest way on a tie
          if (!empty) begin
            worst = 0;
            w     = 0;
            for (int i = 0; i < NUM_WAYS; i++) begin
              if (line_age[s][i] > worst) begin
                worst = line_age[s][i];
                w     = i;
              end
            end
            r.vic_valid = 1'b1;
            r.vic_dirty = line_dty[s][w];
            r.vic_block = line_blk[s][w];
          end
          line_ok[s][w]  = 1'b1;
          line_dty[s][w] = (cmd == ACC_WRITE);
          line_blk[s][w] = blk;
        end
        // move the touched way to the front, younger ways age by one
        old_age = line_age[s][w];
        for (int i = 0; i < NUM_WAYS; i++) begin
          if (line_age[s][i] < old_age) line_age[s][i] = line_age[s][i] + 3'd1;
        end
        line_age[s][w] = '0;
        r.way = w[WAY_OUT_W-1:0];
      end
      ACC_INVAL: begin
        // only a hit drops the line; recency stays as it was
        if (found) begin
          r.hit          = 1'b1;
          r.way          = w[WAY_OUT_W-1:0];
          line_ok[s][w]  = 1'b0;
          line_dty[s][w] = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_bad(string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned got_v);
    if (exp_v !== got_v)
      report_bad($sformatf("%s mismatch: expected 0x%0h got 0x%0h", name, exp_v, got_v));
  endtask

  task automatic push_access(access_e cmd, logic [31:0] addr);
    access_t a;
    a.cmd  = cmd;
    a.addr = addr;
    access_q.push_back(a);
  endtask

  // byte address of block k in set 0
  function automatic logic [31:0] set0_addr(int k);
    return 32'(k) << (OFS_BITS + SET_BITS);
  endfunction

  // driver: offers words from access_q, predicts each word when it is taken
  always @(posedge clk_i or negedge rst_ni) begin : driver
    access_t nxt;
    int      tx_gap;
    int      tx_pct;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_gap = 0;
      tx_pct = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        lookup_due_q.push_back(tag_access(access_e'(command_i), address_i));
        words_in++;
        // new idling mix every 80 words, one of them with none at all
        if (words_in % 80 == 0) begin
          case ($urandom_range(0, 2))
            0:       tx_pct = 0;
            1:       tx_pct = 15;
            default: tx_pct = 50;
          endcase
        end
      end
      if (!in_valid_i || in_ready_o) begin
        if (tx_gap > 0) begin
          in_valid_i <= 1'b0;
          tx_gap--;
        end else if (access_q.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (!quiet_run && $urandom_range(0, 99) < tx_pct) begin
          // start an idle burst
          in_valid_i <= 1'b0;
          tx_gap = $urandom_range(0, 16);
        end else begin
          nxt = access_q.pop_front();
          command_i  <= nxt.cmd;
          address_i  <= nxt.addr;
          in_valid_i <= 1'b1;
        end
      end
      quiet_run <= (access_q.size() < TAIL_WORDS);
    end
  end

  // monitor: drives out_ready_i with random stalls and checks each result word
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    lookup_t exp_r;
    int      rx_gap;
    int      rx_pct;
    int      rx_words;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_gap   = 0;
      rx_pct   = 20;
      rx_words = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        rx_words++;
        if (rx_words % 80 == 40) begin
          case ($urandom_range(0, 2))
            0:       rx_pct = 0;
            1:       rx_pct = 15;
            default: rx_pct = 50;
          endcase
        end
        if (lookup_due_q.size() == 0) begin
          report_bad($sformatf("result word with nothing pending: hit %0b way %0d",
                               hit_o, way_o));
        end else begin
          exp_r = lookup_due_q.pop_front();
          check_field("hit",          exp_r.hit,       hit_o);
          check_field("way",          exp_r.way,       way_o);
          check_field("victim_valid", exp_r.vic_valid, victim_valid_o);
          check_field("victim_dirty", exp_r.vic_dirty, victim_dirty_o);
          check_field("victim_block", exp_r.vic_block, victim_block_o);
        end
      end
      if (rx_hold) begin
        out_ready_i <= 1'b0;
      end else if (rx_gap > 0) begin
        out_ready_i <= 1'b0;
        rx_gap--;
      end else if (!quiet_run && $urandom_range(0, 99) < rx_pct) begin
        out_ready_i <= 1'b0;
        rx_gap = $urandom_range(0, 16);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // long receiver hold-off so the block backs up and drops in_ready_o
  initial begin
    wait (words_in >= HOLD_AFTER);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // watchdog, sized well past the slowest legal run including the clearing pass
  always @(posedge clk_i) begin : watchdog
    int cycle_cnt;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    logic [SET_BITS-1:0] hot_set [4];
    logic [19:0]         hot_tag [12];
    logic [31:0]         a;
    access_e             c;
    int                  r;

    // shadow store after reset: all lines invalid, ranks follow the way index
    for (int s = 0; s < NUM_SETS; s++) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        line_ok[s][w]  = 1'b0;
        line_dty[s][w] = 1'b0;
        line_blk[s][w] = '0;
        line_age[s][w] = w[2:0];
      end
    end

    // directed: nop, invalidate miss on an empty store
    push_access(ACC_NOP, 32'hFFFF_FFFF);
    push_access(ACC_INVAL, 32'h0);
    // fill all eight ways of set 0, first one by a write
    push_access(ACC_WRITE, set0_addr(0));
    for (int k = 1; k < NUM_WAYS; k++) push_access(ACC_READ, set0_addr(k) | 32'h1F);
    // set full: evicts the dirty line in way 0
    push_access(ACC_READ, set0_addr(8));
    // write hit, invalidate hit, then refill lands in the hole
    push_access(ACC_WRITE, set0_addr(1));
    push_access(ACC_INVAL, set0_addr(3));
    push_access(ACC_READ, set0_addr(9));
    // two more evictions of clean lines, then a read hit on the dirty line
    push_access(ACC_WRITE, set0_addr(10));
    push_access(ACC_READ, set0_addr(11));
    push_access(ACC_READ, set0_addr(1));
    // all-ones address: top set, widest block number
    push_access(ACC_READ, 32'hFFFF_FFFF);
    push_access(ACC_WRITE, 32'hFFFF_FFE0);
    push_access(ACC_INVAL, 32'hFFFF_FFFF);
    push_access(ACC_INVAL, 32'hFFFF_FFFF);
    push_access(ACC_NOP, 32'h0);

    // random part: a handful of busy sets and a tag pool larger than the ways,
    // so hits, fills and evictions all come often
    hot_set[0] = '0;
    hot_set[1] = '1;
    hot_set[2] = SET_BITS'($urandom);
    hot_set[3] = SET_BITS'($urandom);
    for (int i = 0; i < 12; i++) hot_tag[i] = 20'($urandom);

    for (int n = 0; n < RAND_WORDS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 40)      c = ACC_READ;
      else if (r < 70) c = ACC_WRITE;
      else if (r < 88) c = ACC_INVAL;
      else             c = ACC_NOP;
      if ($urandom_range(0, 99) < 85) begin
        a[31:OFS_BITS + SET_BITS] = hot_tag[$urandom_range(0, 11)];
        if ($urandom_range(0, 4) != 0)
          a[OFS_BITS + SET_BITS - 1:OFS_BITS] = hot_set[$urandom_range(0, 3)];
        else
          a[OFS_BITS + SET_BITS - 1:OFS_BITS] = SET_BITS'($urandom);
        a[OFS_BITS-1:0] = OFS_BITS'($urandom);
      end else begin
        // scattered address, mostly a miss somewhere else
        a = $urandom;
      end
      push_access(c, a);
    end

    // hold reset, then release it
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drain: everything offered, taken and answered
    while (access_q.size() != 0 || in_valid_i || lookup_due_q.size() != 0)
      @(posedge clk_i);
    // then let the clock run on to catch any stray result word
    repeat (20) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
